// ===== hw/rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Shared constants, register indexes and types for the keyboard serial
// transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_ID    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CODE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MAX_LOW = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_DELAY   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEN    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_LEN      = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_BIT_LEN = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LEN     = 8'd7;

  localparam logic [7:0] LAYOUT_ID_RST    = 8'd0;
  localparam logic [7:0] INIT_CODE_RST    = 8'h80;
  localparam logic [7:0] SYNC_MAX_LOW_RST = 8'd128;
  localparam logic [7:0] LEAD_DELAY_RST   = 8'd10;
  localparam logic [7:0] START_LEN_RST    = 8'd15;
  localparam logic [7:0] BIT_LEN_RST      = 8'd15;
  localparam logic [7:0] LONG_BIT_LEN_RST = 8'd30;
  localparam logic [7:0] STOP_LEN_RST     = 8'd15;

  // refill leaves init code and layout in the first two slots
  localparam logic [PTR_W-1:0] REFILL_WR_PTR = PTR_W'(2);

  typedef struct packed {
    logic [7:0] layout_id;
    logic [7:0] init_code;
    logic [7:0] sync_max_low;
    logic [7:0] lead_delay;
    logic [7:0] start_len;
    logic [7:0] bit_len;
    logic [7:0] long_bit_len;
    logic [7:0] stop_len;
  } cfg_t;

  typedef struct packed {
    logic pop;
    logic refill;
  } ring_ctl_t;

  typedef struct packed {
    logic       empty;
    logic [7:0] head;
  } ring_stat_t;

  typedef struct packed {
    logic busy;
    logic dropped;
    logic level;
    logic enable;
  } result_t;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    wrap_next = (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kst_ring.sv =====
// ----------------------------------------------------------------------------
// kst_ring
// Key byte ring buffer with refill of init code and layout byte.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_ring import kst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire cfg_t       cfg,
  input  wire ring_ctl_t  ctl,
  input  wire logic       write_valid,
  input  wire logic [7:0] write_byte,
  output ring_stat_t      stat,
  output logic            write_dropped
);

  logic [7:0]       store [BUF_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr_mid;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic             wr_en;

  assign stat.empty = (rd_ptr == wr_ptr);
  assign stat.head  = store[rd_ptr];

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_mid  = wr_ptr;
    if (ctl.refill) begin
      rd_ptr_next = '0;
      wr_ptr_mid  = REFILL_WR_PTR;
    end else if (ctl.pop) begin
      rd_ptr_next = wrap_next(rd_ptr);
    end
    wr_ptr_inc    = wrap_next(wr_ptr_mid);
    write_dropped = write_valid && (wr_ptr_inc == rd_ptr_next);
    wr_en         = write_valid && !write_dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      wr_ptr   <= REFILL_WR_PTR;
      store[0] <= INIT_CODE_RST;
      store[1] <= LAYOUT_ID_RST;
    end else if (step) begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_en ? wr_ptr_inc : wr_ptr_mid;
      if (ctl.refill) begin
        store[0] <= cfg.init_code;
        store[1] <= cfg.layout_id;
      end
      if (wr_en) begin
        store[wr_ptr_mid] <= write_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kst_frame.sv =====
// ----------------------------------------------------------------------------
// kst_frame
// Sync pulse measurement and frame sequencer for the line drive.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_frame import kst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire cfg_t       cfg,
  input  wire logic       line_low,
  input  wire ring_stat_t stat,
  output ring_ctl_t       ctl,
  output logic            drive_enable,
  output logic            drive_level,
  output logic            tx_busy
);

  typedef enum logic [2:0] {
    PH_WAIT, PH_SYNC, PH_LEAD, PH_START, PH_DATA, PH_STOP
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] tick_count;
  logic [7:0] tick_count_next;
  logic [7:0] tick_inc;
  logic [2:0] bit_pos;
  logic [2:0] bit_pos_next;
  logic [7:0] tx_byte;
  logic [7:0] tx_byte_next;
  logic [7:0] part_len;
  logic       part_done;
  logic [2:0] src_bit;

  // bits go out as 4,5,6,7,0,1,2,3
  assign src_bit  = bit_pos ^ 3'd4;
  assign tick_inc = (tick_count == 8'hff) ? tick_count : tick_count + 8'd1;

  always_comb begin
    case (phase)
      PH_LEAD:  part_len = cfg.lead_delay;
      PH_START: part_len = cfg.start_len;
      PH_DATA:  part_len = (bit_pos == 3'd3) ? cfg.long_bit_len : cfg.bit_len;
      PH_STOP:  part_len = cfg.stop_len;
      default:  part_len = cfg.stop_len;
    endcase
    part_done = (tick_inc >= part_len);
  end

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_pos_next    = bit_pos;
    tx_byte_next    = tx_byte;
    ctl             = '0;
    drive_enable    = 1'b0;
    drive_level     = 1'b0;
    tx_busy         = 1'b0;
    case (phase)
      PH_WAIT: begin
        if (line_low) begin
          phase_next      = PH_SYNC;
          tick_count_next = 8'd1;
        end
      end
      PH_SYNC: begin
        if (line_low) begin
          tick_count_next = tick_inc;
        end else if (tick_count > cfg.sync_max_low) begin
          ctl.refill      = 1'b1;
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end else if (stat.empty) begin
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end else begin
          ctl.pop         = 1'b1;
          tx_byte_next    = stat.head;
          phase_next      = PH_LEAD;
          tick_count_next = '0;
        end
      end
      PH_LEAD: begin
        tx_busy         = 1'b1;
        tick_count_next = tick_inc;
        if (part_done) begin
          phase_next      = PH_START;
          tick_count_next = '0;
        end
      end
      PH_START: begin
        tx_busy         = 1'b1;
        drive_enable    = 1'b1;
        tick_count_next = tick_inc;
        if (part_done) begin
          phase_next      = PH_DATA;
          tick_count_next = '0;
          bit_pos_next    = '0;
        end
      end
      PH_DATA: begin
        tx_busy         = 1'b1;
        drive_enable    = 1'b1;
        drive_level     = !tx_byte[src_bit];
        tick_count_next = tick_inc;
        if (part_done) begin
          tick_count_next = '0;
          bit_pos_next    = bit_pos + 3'd1;
          if (bit_pos == 3'd7) begin
            phase_next = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        tx_busy         = 1'b1;
        tick_count_next = tick_inc;
        if (part_done) begin
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end
      end
      default: begin
        phase_next      = PH_WAIT;
        tick_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT;
      tick_count <= '0;
      bit_pos    <= '0;
      tx_byte    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_pos    <= bit_pos_next;
      tx_byte    <= tx_byte_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kst_out.sv =====
// ----------------------------------------------------------------------------
// kst_out
// Result register with skid stage toward the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_out import kst_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire result_t result,
  output logic         ready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output logic [7:0]   m_tdata   // enable, level, dropped, busy, zero pad
);

  result_t out_word;
  result_t skid_word;
  logic    skid_valid;
  logic    load;

  assign ready   = !skid_valid;
  assign load    = !m_tvalid || m_tready;
  assign m_tdata = {4'b0000, out_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= step;
      end
    end else if (step) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= skid_valid ? skid_word : result;
    end else if (step) begin
      skid_word <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/keyboard_sync_serial_transmitter.sv =====
// ----------------------------------------------------------------------------
// keyboard_sync_serial_transmitter
// Keyboard side of a one-wire host-polled link: key byte ring buffer,
// sync pulse measurement and framed byte transmit, one word per tick.
// ----------------------------------------------------------------------------
// Output: the result word for an input word is registered.
// Throughput: one word per cycle; input stalls only once the output
//   register and its skid stage both hold words.
// Reset: synchronous; buffer holds init code and layout byte, sequencer
//   waits for a sync low, registers return to their defaults.
`default_nettype none

module keyboard_sync_serial_transmitter import kst_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,   // line_low, write_valid, write_byte, zero pad
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,   // drive_enable, drive_level, write_dropped,
                                               // tx_busy, zero pad
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t       cfg;
  ring_ctl_t  ctl;
  ring_stat_t stat;
  result_t    result;
  logic       step;

  assign cfg_ready = 1'b1;
  assign step      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layout_id    <= LAYOUT_ID_RST;
      cfg.init_code    <= INIT_CODE_RST;
      cfg.sync_max_low <= SYNC_MAX_LOW_RST;
      cfg.lead_delay   <= LEAD_DELAY_RST;
      cfg.start_len    <= START_LEN_RST;
      cfg.bit_len      <= BIT_LEN_RST;
      cfg.long_bit_len <= LONG_BIT_LEN_RST;
      cfg.stop_len     <= STOP_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAYOUT_ID:    cfg.layout_id    <= cfg_data;
        REG_INIT_CODE:    cfg.init_code    <= cfg_data;
        REG_SYNC_MAX_LOW: cfg.sync_max_low <= cfg_data;
        REG_LEAD_DELAY:   cfg.lead_delay   <= cfg_data;
        REG_START_LEN:    cfg.start_len    <= cfg_data;
        REG_BIT_LEN:      cfg.bit_len      <= cfg_data;
        REG_LONG_BIT_LEN: cfg.long_bit_len <= cfg_data;
        REG_STOP_LEN:     cfg.stop_len     <= cfg_data;
        default: ;
      endcase
    end
  end

  kst_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .cfg          (cfg),
    .line_low     (s_tdata[0]),
    .stat         (stat),
    .ctl          (ctl),
    .drive_enable (result.enable),
    .drive_level  (result.level),
    .tx_busy      (result.busy)
  );

  kst_ring u_ring (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .cfg           (cfg),
    .ctl           (ctl),
    .write_valid   (s_tdata[1]),
    .write_byte    (s_tdata[9:2]),
    .stat          (stat),
    .write_dropped (result.dropped)
  );

  kst_out u_out (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .result   (result),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_step_gives_word: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("accepted word produced no result");

  a_level_needs_enable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] || !m_tdata[1]))
    else $error("level driven while line released");

  a_drive_needs_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[0] || m_tdata[3]))
    else $error("line driven outside a frame");

  a_no_pop_on_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (!stat.empty && !ctl.refill))
    else $error("pop from empty buffer");

endmodule

`default_nettype wire

// ===== test/keyboard_sync_serial_transmitter_tb.sv =====
// ----------------------------------------------------------------------------
// keyboard_sync_serial_transmitter_tb
// Streams one tick word per input transfer into the transmitter and predicts
// every output word with a cycle model of the key ring, the sync pulse
// measurement and the frame sequencer. Directed sequences cover power-on
// bytes, overflow, long sync refills and register extremes. Random traffic
// follows, with idle bursts on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_sync_serial_transmitter_tb;
  import kst_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(8);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  typedef enum logic [2:0] {
    LINK_WAIT, LINK_SYNC, LINK_LEAD, LINK_START, LINK_DATA, LINK_STOP
  } link_phase_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [15:0]          s_tdata;    // line_low, write_valid, write_byte[7:0], zero pad
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;    // drive_enable, drive_level, write_dropped, tx_busy,
                                    // zero pad
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  keyboard_sync_serial_transmitter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // link model state
  cfg_t             link_cfg;
  logic [7:0]       key_ring [BUF_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  link_phase_t      link_phase;
  logic [7:0]       tick_cnt;
  logic [2:0]       bit_pos;
  logic [7:0]       frame_byte;

  result_t pending_drive [$];
  result_t got_word;
  result_t want_word;
  int      drive_errors = 0;
  int      words_sent = 0;
  int      cycle_count = 0;
  int      write_pct = 0;
  bit      sender_idle = 1'b0;
  bit      sink_idle = 1'b0;
  bit      hold_request = 1'b0;

  function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % BUF_DEPTH);
  endfunction

  function automatic void requeue_announce();
    key_ring[0] = link_cfg.init_code;
    key_ring[1] = link_cfg.layout_id;
    rd_ptr = '0;
    wr_ptr = PTR_W'(2);
  endfunction

  function automatic void reset_link_model();
    link_cfg.layout_id    = LAYOUT_ID_RST;
    link_cfg.init_code    = INIT_CODE_RST;
    link_cfg.sync_max_low = SYNC_MAX_LOW_RST;
    link_cfg.lead_delay   = LEAD_DELAY_RST;
    link_cfg.start_len    = START_LEN_RST;
    link_cfg.bit_len      = BIT_LEN_RST;
    link_cfg.long_bit_len = LONG_BIT_LEN_RST;
    link_cfg.stop_len     = STOP_LEN_RST;
    for (int i = 0; i < BUF_DEPTH; i++) key_ring[i] = '0;
    requeue_announce();
    link_phase = LINK_WAIT;
    tick_cnt   = '0;
    bit_pos    = '0;
    frame_byte = '0;
  endfunction

  // one tick of a timed part; zero length still takes one tick
  function automatic bit part_done(input logic [7:0] len);
    if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 8'd1;
    return tick_cnt >= len;
  endfunction

  function automatic result_t predict_line_tick(input logic low, input logic wv,
                                                input logic [7:0] wb);
    result_t          r;
    logic [2:0]       sent_bit;
    logic [PTR_W-1:0] nxt;
    r = '0;
    case (link_phase)
      LINK_WAIT: begin
        if (low) begin
          link_phase = LINK_SYNC;
          tick_cnt = 8'd1;
        end
      end
      LINK_SYNC: begin
        if (low) begin
          if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 8'd1;
        end else if (tick_cnt > link_cfg.sync_max_low) begin
          requeue_announce();
          link_phase = LINK_WAIT;
          tick_cnt = '0;
        end else if (rd_ptr == wr_ptr) begin
          link_phase = LINK_WAIT;
          tick_cnt = '0;
        end else begin
          frame_byte = key_ring[rd_ptr];
          rd_ptr = ring_advance(rd_ptr);
          link_phase = LINK_LEAD;
          tick_cnt = '0;
        end
      end
      LINK_LEAD: begin
        r.busy = 1'b1;
        if (part_done(link_cfg.lead_delay)) begin
          link_phase = LINK_START;
          tick_cnt = '0;
        end
      end
      LINK_START: begin
        r.busy = 1'b1;
        r.enable = 1'b1;
        if (part_done(link_cfg.start_len)) begin
          link_phase = LINK_DATA;
          tick_cnt = '0;
          bit_pos = '0;
        end
      end
      LINK_DATA: begin
        // bits go out as 4,5,6,7,0,1,2,3; a one pulls the line low
        sent_bit = bit_pos + 3'd4;
        r.busy = 1'b1;
        r.enable = 1'b1;
        r.level = ~frame_byte[sent_bit];
        if (part_done((bit_pos == 3'd3) ? link_cfg.long_bit_len : link_cfg.bit_len)) begin
          tick_cnt = '0;
          if (bit_pos == 3'd7) begin
            bit_pos = '0;
            link_phase = LINK_STOP;
          end else begin
            bit_pos = bit_pos + 3'd1;
          end
        end
      end
      LINK_STOP: begin
        r.busy = 1'b1;
        if (part_done(link_cfg.stop_len)) begin
          link_phase = LINK_WAIT;
          tick_cnt = '0;
        end
      end
      default: begin
        link_phase = LINK_WAIT;
        tick_cnt = '0;
      end
    endcase
    if (wv) begin
      nxt = ring_advance(wr_ptr);
      if (nxt == rd_ptr) begin
        r.dropped = 1'b1;
      end else begin
        key_ring[wr_ptr] = wb;
        wr_ptr = nxt;
      end
    end
    return r;
  endfunction

  task automatic send_word(input logic low, input logic wv, input logic [7:0] wb);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, wb, wv, low};
    do @(posedge clk); while (!s_tready);
    pending_drive.push_back(predict_line_tick(low, wv, wb));
    words_sent++;
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic tick_random(input logic low);
    send_word(low, $urandom_range(0, 99) < write_pct, 8'($urandom_range(0, 255)));
  endtask

  task automatic pulse(input int len);
    repeat (len) tick_random(1'b1);
    tick_random(1'b0);
  endtask

  // line is ignored while a frame is out, so it toggles freely there
  task automatic finish_frame();
    while (link_phase != LINK_WAIT)
      tick_random((link_phase == LINK_SYNC) ? 1'b0 : 1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    finish_frame();
    s_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LAYOUT_ID:    link_cfg.layout_id    = val;
      REG_INIT_CODE:    link_cfg.init_code    = val;
      REG_SYNC_MAX_LOW: link_cfg.sync_max_low = val;
      REG_LEAD_DELAY:   link_cfg.lead_delay   = val;
      REG_START_LEN:    link_cfg.start_len    = val;
      REG_BIT_LEN:      link_cfg.bit_len      = val;
      REG_LONG_BIT_LEN: link_cfg.long_bit_len = val;
      REG_STOP_LEN:     link_cfg.stop_len     = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    settle();
    write_reg(REG_LAYOUT_ID, c.layout_id);
    write_reg(REG_INIT_CODE, c.init_code);
    write_reg(REG_SYNC_MAX_LOW, c.sync_max_low);
    write_reg(REG_LEAD_DELAY, c.lead_delay);
    write_reg(REG_START_LEN, c.start_len);
    write_reg(REG_BIT_LEN, c.bit_len);
    write_reg(REG_LONG_BIT_LEN, c.long_bit_len);
    write_reg(REG_STOP_LEN, c.stop_len);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_power_on_queue();
    write_pct = 0;
    sender_idle = 1'b1;
    sink_idle = 1'b1;
    pulse(5);
    finish_frame();
    pulse(int'(link_cfg.sync_max_low));
    finish_frame();
    pulse(3);
    pulse(int'(link_cfg.sync_max_low) + 1);
    pulse(1);
    finish_frame();
  endtask

  task automatic test_buffer_overflow();
    cfg_t c;
    // short frames keep this part brief
    c = link_cfg;
    c.sync_max_low = 8'd8;
    c.lead_delay   = 8'd2;
    c.start_len    = 8'd2;
    c.bit_len      = 8'd2;
    c.long_bit_len = 8'd3;
    c.stop_len     = 8'd2;
    apply_settings(c);
    write_pct = 0;
    send_word(1'b0, 1'b1, 8'h00);
    send_word(1'b0, 1'b1, 8'hFF);
    repeat (16) send_word(1'b0, 1'b1, 8'($urandom_range(0, 255)));
    // pop and write on the same tick with the ring full
    send_word(1'b1, 1'b0, 8'h00);
    send_word(1'b1, 1'b0, 8'h00);
    send_word(1'b0, 1'b1, 8'h3C);
    finish_frame();
    // refill and write on the same tick
    repeat (int'(link_cfg.sync_max_low) + 1) send_word(1'b1, 1'b0, 8'h00);
    send_word(1'b0, 1'b1, 8'hC3);
    repeat (3) begin
      pulse(1);
      finish_frame();
    end
    settle();
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    write_pct = 0;
    c.layout_id    = 8'hFF;
    c.init_code    = 8'h00;
    c.sync_max_low = 8'hFF;
    c.lead_delay   = 8'hFF;
    c.start_len    = 8'h01;
    c.bit_len      = 8'h01;
    c.long_bit_len = 8'h01;
    c.stop_len     = 8'h01;
    apply_settings(c);
    send_word(1'b0, 1'b1, 8'hA5);
    // count saturates, so this still reads as a sync pulse
    pulse(260);
    finish_frame();
    c.sync_max_low = 8'h00;
    c.lead_delay   = 8'h00;
    c.start_len    = 8'h00;
    c.bit_len      = 8'h00;
    c.long_bit_len = 8'h00;
    c.stop_len     = 8'h00;
    apply_settings(c);
    pulse(1);
    c.sync_max_low = 8'h01;
    apply_settings(c);
    pulse(1);
    finish_frame();
    // new init/layout values only land after a long sync
    c.layout_id = 8'h5A;
    c.init_code = 8'hC3;
    apply_settings(c);
    pulse(1);
    finish_frame();
    pulse(1);
    pulse(2);
    pulse(1);
    finish_frame();
    settle();
    write_reg(REG_UNUSED_LO, 8'h01);
    write_reg(REG_UNUSED_HI, 8'h00);
    cfg_valid <= 1'b0;
    pulse(1);
    finish_frame();
  endtask

  task automatic test_output_backpressure();
    sender_idle = 1'b0;
    sink_idle = 1'b0;
    write_pct = 30;
    hold_request = 1'b1;
    repeat (60) tick_random(1'($urandom_range(0, 1)));
    settle();
  endtask

  task automatic test_random_traffic(input int n_words, input int len_hi, input int sml_hi,
                                     input bit allow_idle);
    cfg_t c;
    int   stop_at;
    int   pick;
    int   cap;
    c.layout_id    = 8'($urandom_range(0, 255));
    c.init_code    = 8'($urandom_range(0, 255));
    c.sync_max_low = 8'($urandom_range(1, sml_hi));
    c.lead_delay   = 8'($urandom_range(0, len_hi));
    c.start_len    = 8'($urandom_range(0, len_hi));
    c.bit_len      = 8'($urandom_range(0, len_hi));
    c.long_bit_len = 8'($urandom_range(0, len_hi));
    c.stop_len     = 8'($urandom_range(0, len_hi));
    apply_settings(c);
    write_pct = ($urandom_range(0, 1) != 0) ? 40 : 8;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      sender_idle = allow_idle && ($urandom_range(0, 3) != 0);
      sink_idle = allow_idle && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      cap = (link_cfg.sync_max_low > 6) ? 6 : int'(link_cfg.sync_max_low);
      if (pick < 7) begin
        pulse($urandom_range(1, cap));
        finish_frame();
        repeat ($urandom_range(0, 3)) tick_random(1'b0);
      end else if (pick == 7) begin
        pulse(int'(link_cfg.sync_max_low) + $urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(1, 8)) tick_random(1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_link_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_power_on_queue();
    test_buffer_overflow();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic(50, 1, 12, 1'b1);
    test_random_traffic(50, 3, 254, 1'b1);
    test_random_traffic(50, 6, 8, 1'b1);
    test_random_traffic(80, 2, 6, 1'b0);
    settle();
    if (drive_errors == 0) begin
      $display("keyboard_sync_serial_transmitter test passed");
    end else begin
      $display("keyboard_sync_serial_transmitter test failed");
    end
    $finish;
  end

  // output sink: random stalls plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word = result_t'(m_tdata[3:0]);
      if (pending_drive.size() == 0) begin
        drive_errors++;
        if (drive_errors <= 10) $display("unexpected output word %h", m_tdata);
      end else begin
        want_word = pending_drive.pop_front();
        if (got_word.enable !== want_word.enable || got_word.level !== want_word.level ||
            got_word.dropped !== want_word.dropped || got_word.busy !== want_word.busy) begin
          drive_errors++;
          if (drive_errors <= 10)
            $display("mismatch: exp en=%b lvl=%b drop=%b busy=%b got en=%b lvl=%b drop=%b busy=%b",
                     want_word.enable, want_word.level, want_word.dropped, want_word.busy,
                     got_word.enable, got_word.level, got_word.dropped, got_word.busy);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("keyboard_sync_serial_transmitter test failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
